[hdl/sefr_pkg.sv]
`default_nettype none

package sefr_pkg;

  // Framing bytes of the serial protocol.
  localparam logic [7:0] SYNC_BYTE = 8'hE0;
  localparam logic [7:0] ESC_BYTE  = 8'hD0;

  // Node ids and status placed in every reply header.
  localparam logic [7:0] REPLY_DST    = 8'h02;
  localparam logic [7:0] REPLY_SRC    = 8'h01;
  localparam logic [7:0] REPLY_STATUS = 8'h01;

  // Command codes, taken from message byte 0.
  localparam logic [7:0] CMD_BOARD_INFO   = 8'hF0;
  localparam logic [7:0] CMD_PROTO_VER    = 8'hF3;
  localparam logic [7:0] CMD_FW_SUM       = 8'hF2;
  localparam logic [7:0] CMD_STATUS       = 8'hF1;
  localparam logic [7:0] CMD_SET_TIMEOUT  = 8'h11;
  localparam logic [7:0] CMD_RESET        = 8'h10;
  localparam logic [7:0] CMD_DISABLE_RESP = 8'h14;
  localparam logic [7:0] CMD_SET_LED      = 8'h82;

  // Message index of the right LED group's red byte.
  localparam int unsigned LED_RIGHT_BASE = 1 + 59 * 3;

  // Default depth of the message store.
  localparam int unsigned MESSAGE_DEPTH_DEF = 256;

  // Output stream layout.
  localparam int unsigned TDATA_W = 56;
  localparam int unsigned TUSER_W = 2;
  localparam logic [TUSER_W-1:0] USER_TX  = 2'b01;
  localparam logic [TUSER_W-1:0] USER_LED = 2'b10;

  // Number of message bytes read before a command is decoded.
  localparam int unsigned FETCH_N = 7;

  // Board info reply body.
  localparam int unsigned BOARD_INFO_LEN = 18;
  localparam logic [7:0] BOARD_INFO [BOARD_INFO_LEN] = '{
    8'hF0, 8'h01, 8'h31, 8'h35, 8'h30, 8'h39, 8'h33, 8'h2D, 8'h30, 8'h36,
    8'h0A, 8'h36, 8'h37, 8'h31, 8'h30, 8'h41, 8'hFF, 8'hA0
  };

  // Reply sequencer states.
  typedef enum logic [2:0] {
    TX_IDLE,
    TX_FETCH,
    TX_DECIDE,
    TX_SEND,
    TX_LED
  } tx_state_e;

  // Message address read in each fetch slot.
  function automatic logic [7:0] fetch_addr(input logic [2:0] k);
    logic [7:0] a;
    case (k)
      3'd0:    a = 8'd0;
      3'd1:    a = 8'd1;
      3'd2:    a = 8'd2;
      3'd3:    a = 8'd3;
      3'd4:    a = 8'(LED_RIGHT_BASE);
      3'd5:    a = 8'(LED_RIGHT_BASE + 1);
      3'd6:    a = 8'(LED_RIGHT_BASE + 2);
      default: a = 8'd0;
    endcase
    return a;
  endfunction

  // Reply body length; zero means the command gets no reply frame.
  function automatic logic [4:0] rep_len(input logic [7:0] cmd);
    logic [4:0] n;
    case (cmd)
      CMD_BOARD_INFO:   n = 5'(BOARD_INFO_LEN);
      CMD_PROTO_VER:    n = 5'd5;
      CMD_FW_SUM:       n = 5'd4;
      CMD_STATUS:       n = 5'd5;
      CMD_SET_TIMEOUT:  n = 5'd4;
      CMD_RESET:        n = 5'd3;
      CMD_DISABLE_RESP: n = 5'd3;
      default:          n = 5'd0;
    endcase
    return n;
  endfunction

  // Byte j of the reply body; m1 and m2 are message bytes 1 and 2.
  function automatic logic [7:0] rep_byte(input logic [7:0] cmd, input logic [4:0] j,
                                          input logic [7:0] m1, input logic [7:0] m2);
    logic [7:0] b;
    b = 8'h00;
    case (cmd)
      CMD_BOARD_INFO: begin
        if (j < 5'(BOARD_INFO_LEN)) b = BOARD_INFO[j];
      end
      CMD_PROTO_VER: begin
        case (j)
          5'd0:    b = CMD_PROTO_VER;
          5'd1:    b = 8'h01;
          5'd2:    b = 8'h01;
          5'd3:    b = 8'h01;
          default: b = 8'h00;
        endcase
      end
      CMD_FW_SUM: begin
        case (j)
          5'd0:    b = CMD_FW_SUM;
          5'd1:    b = 8'h01;
          5'd2:    b = 8'hAA;
          5'd3:    b = 8'h53;
          default: b = 8'h00;
        endcase
      end
      CMD_STATUS: begin
        case (j)
          5'd0:    b = CMD_STATUS;
          5'd1:    b = 8'h01;
          default: b = 8'h00;
        endcase
      end
      CMD_SET_TIMEOUT: begin
        case (j)
          5'd0:    b = CMD_SET_TIMEOUT;
          5'd1:    b = 8'h01;
          5'd2:    b = m1;
          5'd3:    b = m2;
          default: b = 8'h00;
        endcase
      end
      CMD_RESET: begin
        case (j)
          5'd0:    b = CMD_RESET;
          5'd1:    b = 8'h01;
          default: b = 8'h00;
        endcase
      end
      CMD_DISABLE_RESP: begin
        case (j)
          5'd0:    b = CMD_DISABLE_RESP;
          5'd1:    b = 8'h01;
          5'd2:    b = m1;
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[hdl/sefr_msg_ram.sv]
`default_nettype none

module sefr_msg_ram
  import sefr_pkg::*;
#(
  parameter int unsigned MESSAGE_DEPTH = MESSAGE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(MESSAGE_DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [7:0]    rd_data_o,
  output logic               clearing_o
);

  logic [7:0]    mem [MESSAGE_DEPTH];
  logic          clearing_q, clearing_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  // After reset, one sweep writes zeros to every entry.
  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(MESSAGE_DEPTH - 1)) clearing_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // The sweep owns the write port until it is done.
  assign we    = clearing_q | wr_en_i;
  assign waddr = clearing_q ? clr_addr_q : wr_addr_i;
  assign wdata = clearing_q ? 8'h00 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

  assign clearing_o = clearing_q;

endmodule

`default_nettype wire

[hdl/sefr_rx.sv]
`default_nettype none

module sefr_rx
  import sefr_pkg::*;
#(
  parameter int unsigned MESSAGE_DEPTH = MESSAGE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(MESSAGE_DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    rx_byte_i,
  output logic               wr_en_o,
  output logic      [AW-1:0] wr_addr_o,
  output logic      [7:0]    wr_data_o,
  output logic               start_o
);

  logic       in_frame_q, in_frame_d;
  logic       esc_q, esc_d;
  logic [1:0] phase_q, phase_d;
  logic [7:0] count_q, count_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] len_q, len_d;
  logic [7:0] data;

  // Byte after an escape mark is taken one higher.
  assign data = esc_q ? rx_byte_i + 8'd1 : rx_byte_i;

  // Frame parser: header fields, message bytes into the store, sum check.
  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    phase_d    = phase_q;
    count_d    = count_q;
    sum_d      = sum_q;
    len_d      = len_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = count_q[AW-1:0];
    wr_data_o  = data;
    start_o    = 1'b0;
    if (accept_i) begin
      if (rx_byte_i == SYNC_BYTE) begin
        in_frame_d = 1'b1;
        esc_d      = 1'b0;
        phase_d    = 2'd0;
        count_d    = 8'd0;
        sum_d      = 8'd0;
      end else if (in_frame_q) begin
        if (rx_byte_i == ESC_BYTE) begin
          esc_d = 1'b1;
        end else begin
          esc_d = 1'b0;
          case (phase_q)
            2'd0, 2'd1: begin
              sum_d   = sum_q + data;
              phase_d = phase_q + 2'd1;
            end
            2'd2: begin
              len_d   = data;
              sum_d   = sum_q + data;
              phase_d = 2'd3;
            end
            default: begin
              if (count_q >= len_q) begin
                in_frame_d = 1'b0;
                start_o    = (sum_q == data);
              end else begin
                sum_d   = sum_q + data;
                wr_en_o = ({1'b0, count_q} < 9'(MESSAGE_DEPTH));
                count_d = count_q + 8'd1;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      phase_q    <= 2'd0;
      count_q    <= 8'd0;
      sum_q      <= 8'd0;
      len_q      <= 8'd0;
    end else begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      phase_q    <= phase_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      len_q      <= len_d;
    end
  end

endmodule

`default_nettype wire

[hdl/sefr_tx.sv]
`default_nettype none

module sefr_tx
  import sefr_pkg::*;
#(
  parameter int unsigned MESSAGE_DEPTH = MESSAGE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(MESSAGE_DEPTH)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic      [AW-1:0]      rd_addr_o,
  input  wire logic [7:0]         rd_data_i,
  output logic                    busy_o,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic      [TDATA_W-1:0] m_axis_tdata_o,
  output logic      [TUSER_W-1:0] m_axis_tuser_o,
  output logic                    m_axis_tlast_o
);

  tx_state_e          state_q, state_d;
  logic [2:0]         fetch_q, fetch_d;
  logic [7:0]         slot_q [FETCH_N];
  logic               slot_we;
  logic [4:0]         idx_q, idx_d;
  logic [7:0]         sum_q, sum_d;
  logic               esc_q, esc_d;
  logic               valid_q, valid_d;
  logic [TDATA_W-1:0] data_q, data_d;
  logic [TUSER_W-1:0] user_q, user_d;
  logic               last_q, last_d;
  logic               out_free;
  logic [7:0]         cmd;
  logic [4:0]         len;
  logic [4:0]         last_idx;
  logic [7:0]         raw;
  logic               is_last;

  assign cmd      = slot_q[0];
  assign len      = rep_len(cmd);
  assign last_idx = len + 5'd5;
  assign is_last  = (idx_q == last_idx);
  assign out_free = !valid_q || m_axis_tready_i;

  // Unescaped reply byte at the current position: sync, header, body, sum.
  always_comb begin
    case (idx_q)
      5'd0:    raw = SYNC_BYTE;
      5'd1:    raw = REPLY_DST;
      5'd2:    raw = REPLY_SRC;
      5'd3:    raw = {3'b000, len} + 8'd1;
      5'd4:    raw = REPLY_STATUS;
      default: raw = is_last ? sum_q : rep_byte(cmd, idx_q - 5'd5, slot_q[1], slot_q[2]);
    endcase
  end

  // Fetch of the message bytes, then the reply or LED result.
  always_comb begin
    state_d   = state_q;
    fetch_d   = fetch_q;
    idx_d     = idx_q;
    sum_d     = sum_q;
    esc_d     = esc_q;
    valid_d   = valid_q;
    data_d    = data_q;
    user_d    = user_q;
    last_d    = last_q;
    slot_we   = 1'b0;
    rd_addr_o = AW'(fetch_addr(fetch_q));
    if (valid_q && m_axis_tready_i) valid_d = 1'b0;
    case (state_q)
      TX_IDLE: begin
        if (start_i) begin
          state_d = TX_FETCH;
          fetch_d = 3'd0;
        end
      end
      TX_FETCH: begin
        slot_we = (fetch_q != 3'd0);
        fetch_d = fetch_q + 3'd1;
        if (fetch_q == 3'(FETCH_N)) state_d = TX_DECIDE;
      end
      TX_DECIDE: begin
        idx_d = 5'd0;
        sum_d = 8'd0;
        esc_d = 1'b0;
        if (cmd == CMD_SET_LED) begin
          state_d = TX_LED;
        end else if (len != 5'd0) begin
          state_d = TX_SEND;
        end else begin
          state_d = TX_IDLE;
        end
      end
      TX_SEND: begin
        if (out_free) begin
          valid_d = 1'b1;
          user_d  = USER_TX;
          if (idx_q != 5'd0 && (raw == SYNC_BYTE || raw == ESC_BYTE) && !esc_q) begin
            // First half of an escaped byte.
            data_d = {{(TDATA_W-8){1'b0}}, ESC_BYTE};
            last_d = 1'b0;
            esc_d  = 1'b1;
          end else begin
            data_d = {{(TDATA_W-8){1'b0}}, (esc_q ? raw - 8'd1 : raw)};
            last_d = is_last;
            esc_d  = 1'b0;
            if (idx_q != 5'd0 && !is_last) sum_d = sum_q + raw;
            idx_d = idx_q + 5'd1;
            if (is_last) state_d = TX_IDLE;
          end
        end
      end
      TX_LED: begin
        if (out_free) begin
          valid_d = 1'b1;
          user_d  = USER_LED;
          last_d  = 1'b0;
          data_d  = {slot_q[6], slot_q[5], slot_q[4], slot_q[3], slot_q[2], slot_q[1], 8'h00};
          state_d = TX_IDLE;
        end
      end
      default: state_d = TX_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TX_IDLE;
      fetch_q <= 3'd0;
      idx_q   <= 5'd0;
      sum_q   <= 8'd0;
      esc_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fetch_q <= fetch_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      esc_q   <= esc_d;
      valid_q <= valid_d;
    end
  end

  // Output payload and fetched message bytes.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    user_q <= user_d;
    last_q <= last_d;
    if (slot_we) slot_q[fetch_q - 3'd1] <= rd_data_i;
  end

  assign busy_o          = (state_q != TX_IDLE);
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = user_q;
  assign m_axis_tlast_o  = last_q;

endmodule

`default_nettype wire

[hdl/sync_escape_frame_responder.sv]
// Escaped serial frame receiver that answers a small command set. Received
// bytes enter one per transfer on the slave stream; a frame starts at sync,
// escaped bytes are restored, message bytes go into a message store, and on
// a good sum the command byte selects a reply. Replies leave on the master
// stream one byte per transfer as an escaped frame (tuser bit 0, tlast on
// the sum byte); a set-LED command leaves as a single transfer carrying both
// colour groups (tuser bit 1). A byte that completes no good frame leaves
// the input ready for the next byte. The byte that completes a good frame
// holds the input while seven message bytes are read through the one read
// port and the command is decoded, then while the reply goes out: up to
// 24 transfers for the longest reply, one per cycle while the output is not
// stalled. After reset the store is cleared one entry per cycle, and no
// byte is taken until that pass ends.
`default_nettype none

module sync_escape_frame_responder
  import sefr_pkg::*;
#(
  parameter int unsigned MESSAGE_DEPTH = MESSAGE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [7:0]         s_axis_tdata_i,  // [7:0] rx_byte
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // [7:0] tx_octet, [15:8] left_red, [23:16] left_green, [31:24] left_blue,
  // [39:32] right_red, [47:40] right_green, [55:48] right_blue
  output logic      [TDATA_W-1:0] m_axis_tdata_o,
  output logic      [TUSER_W-1:0] m_axis_tuser_o,  // [0] tx_valid, [1] led_valid
  output logic                    m_axis_tlast_o   // tx_last
);

  localparam int unsigned AW = $clog2(MESSAGE_DEPTH);

  logic          accept;
  logic          clearing;
  logic          busy;
  logic          start;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // One byte at a time: hold input while clearing or replying.
  assign s_axis_tready_o = !clearing && !busy;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  sefr_rx #(
    .MESSAGE_DEPTH(MESSAGE_DEPTH)
  ) u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (s_axis_tdata_i),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .start_o   (start)
  );

  sefr_msg_ram #(
    .MESSAGE_DEPTH(MESSAGE_DEPTH)
  ) u_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .clearing_o (clearing)
  );

  sefr_tx #(
    .MESSAGE_DEPTH(MESSAGE_DEPTH)
  ) u_tx (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .busy_o          (busy),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

[hdl/sefr_checker.sv]
`default_nettype none

module sefr_checker
  import sefr_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_axis_tready_o,
  input wire logic               m_axis_tvalid_o,
  input wire logic               m_axis_tready_i,
  input wire logic [TDATA_W-1:0] m_axis_tdata_o,
  input wire logic [TUSER_W-1:0] m_axis_tuser_o,
  input wire logic               m_axis_tlast_o
);

  // A stalled output transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

  // Every output transfer is either a reply byte or an LED setting.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot(m_axis_tuser_o))
    else $error("output kind flags not one-hot");

  // Reply bytes carry no colour bits.
  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o[TDATA_W-1:8] == '0)
    else $error("reply byte carries colour bits");

  // LED settings carry no reply byte and never end a frame.
  a_led_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> !m_axis_tlast_o && m_axis_tdata_o[7:0] == 8'h00)
    else $error("LED setting carries reply byte fields");

  // While a reply frame is still going out, no received byte is taken.
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input ready in the middle of a reply frame");

endmodule

bind sync_escape_frame_responder sefr_checker u_sefr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

[tb/sefr_reply_checker.sv]
`timescale 1ns / 1ps

// Watches both streams of the frame responder. Every received byte is run
// through a local copy of the frame decoder; replies and LED settings that
// it predicts are queued and compared against the output transfers in order.
module sefr_reply_checker
  import sefr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_tvalid_i,
  input  wire logic               s_tready_i,
  input  wire logic [7:0]         s_tdata_i,
  input  wire logic               m_tvalid_i,
  input  wire logic               m_tready_i,
  input  wire logic [TDATA_W-1:0] m_tdata_i,
  input  wire logic [TUSER_W-1:0] m_tuser_i,
  input  wire logic               m_tlast_i,
  output int unsigned             pending_o,
  output int unsigned             fail_count_o
);

  // One output transfer, split into its fields.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_octet;
    logic       tx_last;
    logic       led_valid;
    logic [7:0] left_red;
    logic [7:0] left_green;
    logic [7:0] left_blue;
    logic [7:0] right_red;
    logic [7:0] right_green;
    logic [7:0] right_blue;
  } reply_t;

  typedef enum logic [1:0] {
    PH_DEST,
    PH_SRC,
    PH_LEN,
    PH_BODY
  } field_phase_e;

  localparam logic [63:0] PART_NUMBER = "15093-06";
  localparam logic [39:0] FW_VERSION  = "6710A";

  reply_t       expected_replies[$];
  int unsigned  mismatch_total;

  // Decoder state mirrored from the block.
  logic         in_frame;
  logic         esc_pending;
  field_phase_e field_phase;
  logic [7:0]   msg_count;
  logic [7:0]   run_sum;
  logic [7:0]   frame_len;
  logic [7:0]   msg_store [MESSAGE_DEPTH_DEF];

  task automatic queue_octet(input logic [7:0] b, input logic last);
    reply_t r;
    r          = '0;
    r.tx_valid = 1'b1;
    r.tx_octet = b;
    r.tx_last  = last;
    expected_replies.push_back(r);
  endtask

  // Sync and escape values travel as an escape byte and the value minus one.
  task automatic queue_escaped(input logic [7:0] b, input logic last);
    logic [7:0] v;
    v = b;
    if (v == SYNC_BYTE || v == ESC_BYTE) begin
      queue_octet(ESC_BYTE, 1'b0);
      v = v - 8'd1;
    end
    queue_octet(v, last);
  endtask

  // Decode the command in message byte 0 and queue what it produces.
  task automatic answer_command();
    logic [7:0] body[$];
    logic [7:0] frame_sum;
    reply_t     led;
    int         i;
    body.delete();
    case (msg_store[0])
      CMD_BOARD_INFO: begin
        body.push_back(CMD_BOARD_INFO);
        body.push_back(8'h01);
        for (i = 7; i >= 0; i--) body.push_back(PART_NUMBER[8*i +: 8]);
        body.push_back(8'h0A);
        for (i = 4; i >= 0; i--) body.push_back(FW_VERSION[8*i +: 8]);
        body.push_back(8'hFF);
        body.push_back(8'hA0);
      end
      CMD_PROTO_VER: begin
        body.push_back(CMD_PROTO_VER); body.push_back(8'h01);
        body.push_back(8'h01); body.push_back(8'h01); body.push_back(8'h00);
      end
      CMD_FW_SUM: begin
        body.push_back(CMD_FW_SUM); body.push_back(8'h01);
        body.push_back(8'hAA); body.push_back(8'h53);
      end
      CMD_STATUS: begin
        body.push_back(CMD_STATUS); body.push_back(8'h01);
        body.push_back(8'h00); body.push_back(8'h00); body.push_back(8'h00);
      end
      CMD_SET_TIMEOUT: begin
        body.push_back(CMD_SET_TIMEOUT); body.push_back(8'h01);
        body.push_back(msg_store[1]); body.push_back(msg_store[2]);
      end
      CMD_RESET: begin
        body.push_back(CMD_RESET); body.push_back(8'h01); body.push_back(8'h00);
      end
      CMD_DISABLE_RESP: begin
        body.push_back(CMD_DISABLE_RESP); body.push_back(8'h01);
        body.push_back(msg_store[1]);
      end
      CMD_SET_LED: begin
        led             = '0;
        led.led_valid   = 1'b1;
        led.left_red    = msg_store[1];
        led.left_green  = msg_store[2];
        led.left_blue   = msg_store[3];
        led.right_red   = msg_store[LED_RIGHT_BASE];
        led.right_green = msg_store[LED_RIGHT_BASE + 1];
        led.right_blue  = msg_store[LED_RIGHT_BASE + 2];
        expected_replies.push_back(led);
      end
      default: ;
    endcase

    // Reply frame: sync, header, status, body and sum, all but sync escaped.
    if (body.size() > 0) begin
      frame_sum = REPLY_DST + REPLY_SRC + 8'(body.size() + 1) + REPLY_STATUS;
      queue_octet(SYNC_BYTE, 1'b0);
      queue_escaped(REPLY_DST, 1'b0);
      queue_escaped(REPLY_SRC, 1'b0);
      queue_escaped(8'(body.size() + 1), 1'b0);
      queue_escaped(REPLY_STATUS, 1'b0);
      for (i = 0; i < body.size(); i++) begin
        frame_sum = frame_sum + body[i];
        queue_escaped(body[i], 1'b0);
      end
      queue_escaped(frame_sum, 1'b1);
    end
  endtask

  // Advance the decoder by one received byte.
  task automatic absorb_rx_byte(input logic [7:0] raw);
    logic [7:0] d;
    d = raw;
    if (d == SYNC_BYTE) begin
      in_frame    = 1'b1;
      esc_pending = 1'b0;
      field_phase = PH_DEST;
      msg_count   = 8'd0;
      run_sum     = 8'd0;
    end else if (in_frame) begin
      if (d == ESC_BYTE) begin
        // A second escape just keeps the first one pending.
        esc_pending = 1'b1;
      end else begin
        if (esc_pending) begin
          d           = d + 8'd1;
          esc_pending = 1'b0;
        end
        case (field_phase)
          PH_DEST: begin
            run_sum     = run_sum + d;
            field_phase = PH_SRC;
          end
          PH_SRC: begin
            run_sum     = run_sum + d;
            field_phase = PH_LEN;
          end
          PH_LEN: begin
            frame_len   = d;
            run_sum     = run_sum + d;
            field_phase = PH_BODY;
          end
          default: begin
            if (msg_count >= frame_len) begin
              // Sum byte: the frame ends whether or not it matches.
              in_frame = 1'b0;
              if (run_sum == d) answer_command();
            end else begin
              run_sum              = run_sum + d;
              msg_store[msg_count] = d;
              msg_count            = msg_count + 8'd1;
            end
          end
        endcase
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_total++;
    end
  endtask

  // Output transfers are compared before the input byte of the same edge is
  // decoded; a reply never leaves in the cycle its last byte is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t got;
    reply_t want;
    int     k;
    if (!rst_ni) begin
      in_frame    = 1'b0;
      esc_pending = 1'b0;
      field_phase = PH_DEST;
      msg_count   = 8'd0;
      run_sum     = 8'd0;
      frame_len   = 8'd0;
      for (k = 0; k < MESSAGE_DEPTH_DEF; k++) msg_store[k] = 8'd0;
      expected_replies.delete();
      mismatch_total = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.tx_valid    = m_tuser_i[0];
        got.led_valid   = m_tuser_i[1];
        got.tx_last     = m_tlast_i;
        got.tx_octet    = m_tdata_i[7:0];
        got.left_red    = m_tdata_i[15:8];
        got.left_green  = m_tdata_i[23:16];
        got.left_blue   = m_tdata_i[31:24];
        got.right_red   = m_tdata_i[39:32];
        got.right_green = m_tdata_i[47:40];
        got.right_blue  = m_tdata_i[55:48];
        if (expected_replies.size() == 0) begin
          $error("output transfer with nothing expected: tdata %h tuser %b tlast %b",
                 m_tdata_i, m_tuser_i, m_tlast_i);
          mismatch_total++;
        end else begin
          want = expected_replies.pop_front();
          check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
          check_field("tx_octet", want.tx_octet, got.tx_octet);
          check_field("tx_last", 8'(want.tx_last), 8'(got.tx_last));
          check_field("led_valid", 8'(want.led_valid), 8'(got.led_valid));
          check_field("left_red", want.left_red, got.left_red);
          check_field("left_green", want.left_green, got.left_green);
          check_field("left_blue", want.left_blue, got.left_blue);
          check_field("right_red", want.right_red, got.right_red);
          check_field("right_green", want.right_green, got.right_green);
          check_field("right_blue", want.right_blue, got.right_blue);
        end
      end
      if (s_tvalid_i && s_tready_i) absorb_rx_byte(s_tdata_i);
    end
    pending_o    <= expected_replies.size();
    fail_count_o <= mismatch_total;
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

// Drives serial bytes into the frame responder: hand-picked frames first,
// then random frames, noise and broken frames, with random gaps and stalls
// on both streams. The checker instance does all prediction and comparison.
module tb;
  import sefr_pkg::*;

  localparam int RX_TARGET      = 310;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 100;

  localparam logic [7:0] COMMANDS [8] = '{
    CMD_BOARD_INFO, CMD_PROTO_VER, CMD_FW_SUM, CMD_STATUS,
    CMD_SET_TIMEOUT, CMD_RESET, CMD_DISABLE_RESP, CMD_SET_LED
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = 8'd0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [TUSER_W-1:0] m_tuser;
  logic               m_tlast;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned rx_bytes_sent = 0;
  int unsigned idle_cycles = 0;
  int          rx_hold_left = 0;
  bit          tx_fast = 1'b0;
  bit          rx_fast = 1'b0;
  logic [7:0]  frame_body[$];

  always #5 clk = ~clk;

  sync_escape_frame_responder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  sefr_reply_checker u_replies (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // One byte on the input stream, after a random gap; called at a falling edge.
  task automatic send_raw(input logic [7:0] b);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 5);
    if ($urandom_range(0, 15) == 0) tx_fast = !tx_fast;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= b;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    rx_bytes_sent++;
  endtask

  // Stop offering bytes and wait at falling edges until every result is out.
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Escape sync and escape values; optionally escape an ordinary byte too,
  // unless its escaped form would itself look like sync or escape.
  task automatic send_coded(input logic [7:0] b, input bit force_esc);
    logic [7:0] dec;
    dec = b - 8'd1;
    if (b == SYNC_BYTE || b == ESC_BYTE ||
        (force_esc && dec != SYNC_BYTE && dec != ESC_BYTE)) begin
      send_raw(ESC_BYTE);
      send_raw(dec);
    end else begin
      send_raw(b);
    end
  endtask

  // Whole frame around frame_body; a bad sum is off by a nonzero pattern.
  task automatic send_frame(input logic [7:0] dst, input logic [7:0] src,
                            input bit bad_sum);
    logic [7:0] sum;
    int         i;
    sum = dst + src + 8'(frame_body.size());
    send_raw(SYNC_BYTE);
    send_coded(dst, $urandom_range(0, 11) == 0);
    send_coded(src, $urandom_range(0, 11) == 0);
    send_coded(8'(frame_body.size()), $urandom_range(0, 11) == 0);
    for (i = 0; i < frame_body.size(); i++) begin
      sum = sum + frame_body[i];
      send_coded(frame_body[i], $urandom_range(0, 11) == 0);
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_coded(sum, $urandom_range(0, 11) == 0);
  endtask

  task automatic build_body(input logic [7:0] cmd, input int len);
    int i;
    frame_body.delete();
    for (i = 0; i < len; i++) frame_body.push_back(8'($urandom_range(0, 255)));
    if (len > 0) frame_body[0] = cmd;
  endtask

  // Output side: random ready gaps, fast stretches, and a long hold on request.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (rx_hold_left > 0) begin
        m_tready <= 1'b0;
        while (rx_hold_left > 0) begin
          @(negedge clk);
          rx_hold_left--;
        end
      end
      gap = rx_fast ? 0 : $urandom_range(0, 5);
      if ($urandom_range(0, 15) == 0) rx_fast = !rx_fast;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Ends the run when neither stream has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sync_escape_frame_responder verification failed");
      $finish;
    end
  end

  initial begin
    int          i;
    int unsigned pick;
    int unsigned random_start;
    bit          hold_done;
    bit          long_done;
    hold_done = 1'b0;
    long_done = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Bytes outside a frame, escape included, are ignored.
    send_raw(8'h00);
    send_raw(8'hFF);
    send_raw(ESC_BYTE);
    send_raw(8'h55);

    // Every command but set-LED once, with short frames.
    for (i = 0; i < 7; i++) begin
      build_body(COMMANDS[i], 3);
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
    end
    // Echoed bytes that need escaping on the way out.
    frame_body.delete();
    frame_body.push_back(CMD_SET_TIMEOUT);
    frame_body.push_back(SYNC_BYTE);
    frame_body.push_back(ESC_BYTE);
    send_frame(8'hFF, 8'h00, 1'b0);
    // A short LED message takes the colours that earlier frames left behind.
    build_body(CMD_SET_LED, 2);
    send_frame(8'h01, 8'h02, 1'b0);
    // Bad sum and unknown command give nothing.
    build_body(CMD_FW_SUM, 1);
    send_frame(8'h01, 8'h02, 1'b1);
    build_body(8'h00, 2);
    send_frame(8'h01, 8'h02, 1'b0);
    // Sync in the middle of a frame starts over.
    send_raw(SYNC_BYTE);
    send_raw(8'h01);
    send_raw(8'h02);
    build_body(CMD_STATUS, 1);
    send_frame(8'h01, 8'h02, 1'b0);
    // Double escape stays pending, and an escaped all-ones byte wraps to zero:
    // destination 02, source 00, length 2, protocol version command, sum F8.
    send_raw(SYNC_BYTE);
    send_raw(ESC_BYTE);
    send_raw(ESC_BYTE);
    send_raw(8'h01);
    send_raw(ESC_BYTE);
    send_raw(8'hFF);
    send_raw(8'h02);
    send_raw(CMD_PROTO_VER);
    send_raw(8'h01);
    send_raw(8'hF8);
    // Empty message: the command comes from whatever the store holds.
    frame_body.delete();
    send_frame(8'h10, 8'h20, 1'b0);
    drain_outputs();

    // Random traffic until the byte budget is spent.
    random_start = rx_bytes_sent;
    while (rx_bytes_sent < RX_TARGET) begin
      pick = $urandom_range(0, 99);
      if (!hold_done && rx_bytes_sent > random_start + 10) begin
        // Output held off while frames keep arriving.
        rx_hold_left = HOLD_CYCLES;
        hold_done    = 1'b1;
        build_body(CMD_BOARD_INFO, 1);
        send_frame(8'h01, 8'h02, 1'b0);
        build_body(CMD_SET_TIMEOUT, 3);
        send_frame(8'h01, 8'h02, 1'b0);
      end else if (!long_done && hold_done) begin
        // Message long enough to set both LED groups.
        long_done = 1'b1;
        build_body(CMD_SET_LED, $urandom_range(181, 184));
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 65) begin
        build_body(COMMANDS[$urandom_range(0, 7)],
                   ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 75) begin
        build_body(COMMANDS[$urandom_range(0, 7)], $urandom_range(1, 6));
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) send_raw(8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
        // Frame cut short; the next sync restarts decoding.
        send_raw(SYNC_BYTE);
        repeat ($urandom_range(1, 5)) send_coded(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        build_body(8'($urandom_range(0, 255)), $urandom_range(1, 6));
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 19) == 0) drain_outputs();
    end

    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sync_escape_frame_responder verification clean");
    end else begin
      $display("sync_escape_frame_responder verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/sefr_pkg.sv
hdl/sefr_msg_ram.sv
hdl/sefr_rx.sv
hdl/sefr_tx.sv
hdl/sync_escape_frame_responder.sv
hdl/sefr_checker.sv
tb/sefr_reply_checker.sv
tb/tb.sv
